>>> sv/gpsn_pkg.sv
// Shared types, codes and helper functions for the grid point store.
package gpsn_pkg;

	typedef enum logic [0:0] {
		FUNC_INSERT = 1'b0,
		FUNC_FIND   = 1'b1
	} func_t;

	typedef enum logic [1:0] {
		ST_INSERTED  = 2'd0,
		ST_FOUND     = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	localparam logic [2:0] REG_ORIGIN_X = 3'd0;
	localparam logic [2:0] REG_ORIGIN_Y = 3'd1;
	localparam logic [2:0] REG_SCALE_X  = 3'd2;
	localparam logic [2:0] REG_SCALE_Y  = 3'd3;
	localparam logic [2:0] REG_COLS     = 3'd4;
	localparam logic [2:0] REG_ROWS     = 3'd5;
	localparam logic [2:0] REG_TOL_SQR  = 3'd6;

	// {sign, magnitude} of a - b for two signed 32-bit values
	function automatic logic [32:0] abs_diff(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] d;
		logic [32:0] n;
		d = {a[31], a} - {b[31], b};
		n = -d;
		abs_diff = {d[32], (d[32] ? n[31:0] : d[31:0])};
	endfunction

	// signed cell coordinate from a Q32.32 product and the sign of the difference
	function automatic logic signed [33:0] cell_raw(input logic neg, input logic [31:0] q);
		logic [33:0] v;
		v = {2'b00, q};
		cell_raw = neg ? $signed(-v) : $signed(v);
	endfunction

endpackage

>>> sv/gpsn_mul.sv
// Shared 32x32 unsigned multiplier with registered product.
module gpsn_mul import gpsn_pkg::*; (
	input  logic        clk,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic [63:0] p
);

	always_ff @(posedge clk) begin
		p <= 64'(a) * 64'(b);
	end

endmodule

>>> sv/gpsn_store.sv
// Bucket head memory and point pool memories with registered reads.
module gpsn_store import gpsn_pkg::*; #(
	parameter int HAW = 16,
	parameter int PW  = 12,
	parameter int PB  = 64
) (
	input  logic            clk,
	input  logic            head_we,
	input  logic [HAW-1:0]  head_waddr,
	input  logic [PW:0]     head_wdata,
	input  logic            head_re,
	input  logic [HAW-1:0]  head_raddr,
	output logic [PW:0]     head_rdata,
	input  logic            pool_we,
	input  logic [PW-1:0]   pool_waddr,
	input  logic [31:0]     pool_wx,
	input  logic [31:0]     pool_wy,
	input  logic [PB-1:0]   pool_wpay,
	input  logic [PW:0]     pool_wlink,
	input  logic            pool_re,
	input  logic [PW-1:0]   pool_raddr,
	output logic [31:0]     pool_rx,
	output logic [31:0]     pool_ry,
	output logic [PB-1:0]   pool_rpay,
	output logic [PW:0]     pool_rlink
);

	logic [PW:0]   heads_mem [2**HAW];
	logic [31:0]   px_mem    [2**PW];
	logic [31:0]   py_mem    [2**PW];
	logic [PB-1:0] pay_mem   [2**PW];
	logic [PW:0]   link_mem  [2**PW];

	always_ff @(posedge clk) begin
		if (head_we) begin
			heads_mem[head_waddr] <= head_wdata;
		end
		if (head_re) begin
			head_rdata <= heads_mem[head_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (pool_we) begin
			px_mem[pool_waddr]   <= pool_wx;
			py_mem[pool_waddr]   <= pool_wy;
			pay_mem[pool_waddr]  <= pool_wpay;
			link_mem[pool_waddr] <= pool_wlink;
		end
		if (pool_re) begin
			pool_rx    <= px_mem[pool_raddr];
			pool_ry    <= py_mem[pool_raddr];
			pool_rpay  <= pay_mem[pool_raddr];
			pool_rlink <= link_mem[pool_raddr];
		end
	end

endmodule

>>> sv/grid_point_store_nearest_search.sv
// Top level: grid point store with insert and nearest-point find.
//
// Input channel (in_valid/in_ready) carries func, x_key, y_key, payload.
// Result channel (out_valid/out_ready) returns status and found_payload,
// one result per input transaction, in order.
// Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes the
// registers; it is always ready. The user must use it only while the block
// is idle; the block itself does not enforce this. After reset the block
// clears all GRID_DIM*GRID_DIM bucket heads (65536 by default), with
// in_ready low. One transaction is processed at a time; in_ready is high
// only when idle. An insert runs S_MULX, S_MULY, S_CELL, S_WIN, S_INS_WR
// (skipped when the pool is full) and S_DONE; a find runs S_F_CELL and
// S_F_HEAD per scanned cell and S_F_POOL, S_F_SQX and S_F_SQY per stored
// point, sharing one 32x32 multiplier and the single pool read port.
// The result sits in an output register; a new transaction may be accepted
// while it waits, and the next result is held back until it is taken.
module grid_point_store_nearest_search import gpsn_pkg::*; #(
	parameter int GRID_DIM     = 256,
	parameter int POOL_SIZE    = 4096,
	parameter int PAYLOAD_BITS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        func,
	input  logic [31:0] x_key,
	input  logic [31:0] y_key,
	input  logic [63:0] payload,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [63:0] found_payload,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data
);

	localparam int CW  = (GRID_DIM > 1) ? $clog2(GRID_DIM) : 1;
	localparam int HD  = GRID_DIM * GRID_DIM;
	localparam int HAW = (HD > 1) ? $clog2(HD) : 1;
	localparam int PW  = $clog2(POOL_SIZE);

	typedef enum logic [12:0] {
		S_CLEAR  = 13'b0000000000001,
		S_IDLE   = 13'b0000000000010,
		S_MULX   = 13'b0000000000100,
		S_MULY   = 13'b0000000001000,
		S_CELL   = 13'b0000000010000,
		S_WIN    = 13'b0000000100000,
		S_INS_WR = 13'b0000001000000,
		S_F_CELL = 13'b0000010000000,
		S_F_HEAD = 13'b0000100000000,
		S_F_POOL = 13'b0001000000000,
		S_F_SQX  = 13'b0010000000000,
		S_F_SQY  = 13'b0100000000000,
		S_DONE   = 13'b1000000000000
	} state_t;

	state_t state_q, state_d;

	logic [31:0] origin_x_q, origin_y_q, scale_x_q, scale_y_q;
	logic [8:0]  cols_q, rows_q;
	logic [63:0] tol_sqr_q;

	logic [HAW-1:0] clr_q;
	logic [PW:0]    fill_q;
	logic           out_valid_q;

	logic              func_q;
	logic [31:0]       xk_q, yk_q;
	logic [PAYLOAD_BITS-1:0] pay_q;
	logic              sx_neg_q, sy_neg_q;
	logic signed [33:0] cxr_q, cyr_q;
	logic [CW-1:0]     x1_q, x2_q, y2_q, gx_q, gy_q;
	logic [HAW-1:0]    ins_cell_q;
	logic [63:0]       a_q, best_q;
	logic [PAYLOAD_BITS-1:0] bpay_q;
	logic              found_q;
	logic [1:0]        ins_status_q;
	logic [1:0]        status_q;
	logic [63:0]       fpay_q;

	logic [31:0] mul_a, mul_b;
	logic [63:0] mul_p;

	logic              head_we, head_re, pool_we, pool_re;
	logic [HAW-1:0]    head_waddr, head_raddr;
	logic [PW:0]       head_wdata, head_rdata;
	logic [PW-1:0]     pool_raddr;
	logic [31:0]       pool_rx, pool_ry;
	logic [PAYLOAD_BITS-1:0] pool_rpay;
	logic [PW:0]       pool_rlink;

	logic [32:0] dx_key, dy_key, dx_pt, dy_pt;
	logic [CW-1:0] ncm1, nrm1;
	logic [CW-1:0] wx1, wx2, wy1, wy2, icx, icy;
	logic [HAW-1:0] ins_cell, scan_cell;
	logic pool_full, last_cell, col_last, out_free;
	logic [64:0] dsum;
	logic [63:0] dist_sat;

	function automatic logic [CW-1:0] dim_m1(input logic [8:0] r);
		logic [CW-1:0] m;
		if (r == 9'd0) begin
			m = '0;
		end else if (r > 9'(GRID_DIM)) begin
			m = CW'(GRID_DIM - 1);
		end else begin
			m = CW'(r - 9'd1);
		end
		dim_m1 = m;
	endfunction

	function automatic logic [CW-1:0] clamp_cell(input logic signed [33:0] v,
			input logic [CW-1:0] nm1);
		logic [CW-1:0] c;
		if (v < 0) begin
			c = '0;
		end else if (v > $signed(34'(nm1))) begin
			c = nm1;
		end else begin
			c = v[CW-1:0];
		end
		clamp_cell = c;
	endfunction

	function automatic logic [HAW-1:0] cell_addr(input logic [CW-1:0] gx,
			input logic [CW-1:0] gy);
		cell_addr = HAW'(HAW'(gy) * HAW'(GRID_DIM) + HAW'(gx));
	endfunction

	assign ncm1 = dim_m1(cols_q);
	assign nrm1 = dim_m1(rows_q);
	assign dx_key = abs_diff(xk_q, origin_x_q);
	assign dy_key = abs_diff(yk_q, origin_y_q);
	assign dx_pt  = abs_diff(xk_q, pool_rx);
	assign dy_pt  = abs_diff(yk_q, pool_ry);
	assign wx1 = clamp_cell(cxr_q - 34'sd1, ncm1);
	assign wx2 = clamp_cell(cxr_q + 34'sd1, ncm1);
	assign wy1 = clamp_cell(cyr_q - 34'sd1, nrm1);
	assign wy2 = clamp_cell(cyr_q + 34'sd1, nrm1);
	assign icx = clamp_cell(cxr_q, ncm1);
	assign icy = clamp_cell(cyr_q, nrm1);
	assign ins_cell  = cell_addr(icx, icy);
	assign scan_cell = cell_addr(gx_q, gy_q);
	assign pool_full = (fill_q == (PW+1)'(POOL_SIZE));
	assign col_last  = (gx_q == x2_q);
	assign last_cell = col_last && (gy_q == y2_q);
	assign out_free  = !out_valid_q || out_ready;
	assign dsum = 65'(a_q) + 65'(mul_p);
	assign dist_sat = dsum[64] ? '1 : dsum[63:0];

	assign in_ready      = (state_q == S_IDLE);
	assign cfg_ready     = 1'b1;
	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign found_payload = fpay_q;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_MULX: begin
				mul_a = dx_key[31:0];
				mul_b = scale_x_q;
			end
			S_MULY: begin
				mul_a = dy_key[31:0];
				mul_b = scale_y_q;
			end
			S_F_POOL: begin
				mul_a = dx_pt[31:0];
				mul_b = dx_pt[31:0];
			end
			S_F_SQX: begin
				mul_a = dy_pt[31:0];
				mul_b = dy_pt[31:0];
			end
			default: ;
		endcase
	end

	always_comb begin
		head_we    = 1'b0;
		head_waddr = clr_q;
		head_wdata = '0;
		head_re    = 1'b0;
		head_raddr = scan_cell;
		pool_we    = 1'b0;
		pool_re    = 1'b0;
		pool_raddr = head_rdata[PW-1:0];
		case (state_q)
			S_CLEAR: head_we = 1'b1;
			S_WIN: begin
				head_re    = (func_q == FUNC_INSERT) && !pool_full;
				head_raddr = ins_cell;
			end
			S_INS_WR: begin
				head_we    = 1'b1;
				head_waddr = ins_cell_q;
				head_wdata = {1'b1, fill_q[PW-1:0]};
				pool_we    = 1'b1;
			end
			S_F_CELL: head_re = 1'b1;
			S_F_HEAD: pool_re = head_rdata[PW];
			S_F_SQY: begin
				pool_re    = pool_rlink[PW];
				pool_raddr = pool_rlink[PW-1:0];
			end
			default: ;
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR:  if (clr_q == HAW'(HD - 1)) state_d = S_IDLE;
			S_IDLE:   if (in_valid) state_d = S_MULX;
			S_MULX:   state_d = S_MULY;
			S_MULY:   state_d = S_CELL;
			S_CELL:   state_d = S_WIN;
			S_WIN: begin
				if (func_q == FUNC_FIND) begin
					state_d = S_F_CELL;
				end else if (pool_full) begin
					state_d = S_DONE;
				end else begin
					state_d = S_INS_WR;
				end
			end
			S_INS_WR: state_d = S_DONE;
			S_F_CELL: state_d = S_F_HEAD;
			S_F_HEAD: begin
				if (head_rdata[PW]) begin
					state_d = S_F_POOL;
				end else if (last_cell) begin
					state_d = S_DONE;
				end else begin
					state_d = S_F_CELL;
				end
			end
			S_F_POOL: state_d = S_F_SQX;
			S_F_SQX:  state_d = S_F_SQY;
			S_F_SQY: begin
				if (pool_rlink[PW]) begin
					state_d = S_F_POOL;
				end else if (last_cell) begin
					state_d = S_DONE;
				end else begin
					state_d = S_F_CELL;
				end
			end
			S_DONE:   if (out_free) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			fill_q      <= '0;
			out_valid_q <= 1'b0;
			origin_x_q  <= '0;
			origin_y_q  <= '0;
			scale_x_q   <= 32'd65536;
			scale_y_q   <= 32'd65536;
			cols_q      <= 9'd256;
			rows_q      <= 9'd256;
			tol_sqr_q   <= 64'd65536;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + HAW'(1);
			end
			if (state_q == S_INS_WR) begin
				fill_q <= fill_q + (PW+1)'(1);
			end
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_valid) begin
				case (cfg_index)
					REG_ORIGIN_X: origin_x_q <= cfg_data[31:0];
					REG_ORIGIN_Y: origin_y_q <= cfg_data[31:0];
					REG_SCALE_X:  scale_x_q  <= cfg_data[31:0];
					REG_SCALE_Y:  scale_y_q  <= cfg_data[31:0];
					REG_COLS:     cols_q     <= cfg_data[8:0];
					REG_ROWS:     rows_q     <= cfg_data[8:0];
					REG_TOL_SQR:  tol_sqr_q  <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				func_q <= func;
				xk_q   <= x_key;
				yk_q   <= y_key;
				pay_q  <= payload[PAYLOAD_BITS-1:0];
			end
			S_MULX: sx_neg_q <= dx_key[32];
			S_MULY: begin
				sy_neg_q <= dy_key[32];
				cxr_q    <= cell_raw(sx_neg_q, mul_p[63:32]);
			end
			S_CELL: cyr_q <= cell_raw(sy_neg_q, mul_p[63:32]);
			S_WIN: begin
				x1_q       <= wx1;
				x2_q       <= wx2;
				y2_q       <= wy2;
				gx_q       <= wx1;
				gy_q       <= wy1;
				ins_cell_q <= ins_cell;
				best_q     <= tol_sqr_q;
				found_q    <= 1'b0;
				ins_status_q <= pool_full ? ST_FULL : ST_INSERTED;
			end
			S_F_HEAD: begin
				if (!head_rdata[PW]) begin
					gx_q <= col_last ? x1_q : gx_q + CW'(1);
					if (col_last) gy_q <= gy_q + CW'(1);
				end
			end
			S_F_SQX: a_q <= mul_p;
			S_F_SQY: begin
				if (best_q > dist_sat) begin
					best_q  <= dist_sat;
					bpay_q  <= pool_rpay;
					found_q <= 1'b1;
				end
				if (!pool_rlink[PW]) begin
					gx_q <= col_last ? x1_q : gx_q + CW'(1);
					if (col_last) gy_q <= gy_q + CW'(1);
				end
			end
			S_DONE: begin
				if (out_free) begin
					if (func_q == FUNC_FIND) begin
						status_q <= found_q ? ST_FOUND : ST_NOT_FOUND;
						fpay_q   <= found_q ? 64'(bpay_q) : '0;
					end else begin
						status_q <= ins_status_q;
						fpay_q   <= '0;
					end
				end
			end
			default: ;
		endcase
	end

	gpsn_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (mul_p)
	);

	gpsn_store #(
		.HAW (HAW),
		.PW  (PW),
		.PB  (PAYLOAD_BITS)
	) u_store (
		.clk        (clk),
		.head_we    (head_we),
		.head_waddr (head_waddr),
		.head_wdata (head_wdata),
		.head_re    (head_re),
		.head_raddr (head_raddr),
		.head_rdata (head_rdata),
		.pool_we    (pool_we),
		.pool_waddr (fill_q[PW-1:0]),
		.pool_wx    (xk_q),
		.pool_wy    (yk_q),
		.pool_wpay  (pay_q),
		.pool_wlink (head_rdata),
		.pool_re    (pool_re),
		.pool_raddr (pool_raddr),
		.pool_rx    (pool_rx),
		.pool_ry    (pool_ry),
		.pool_rpay  (pool_rpay),
		.pool_rlink (pool_rlink)
	);

`ifndef NO_ASSERTIONS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= (PW+1)'(POOL_SIZE))
		else $error("fill count above pool size");

	a_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("state register not one-hot");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == S_MULX)
		else $error("accepted transaction not started");

	a_head_write_src: assert property (@(posedge clk) disable iff (!arst_n)
		head_we |-> (state_q == S_CLEAR || state_q == S_INS_WR))
		else $error("unexpected bucket head write");

	a_full_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		pool_we |-> !pool_full)
		else $error("pool written while full");
`endif

endmodule

>>> tb/grid_point_store_nearest_search_checker.sv
// Checker for the grid point store: tracks the store, predicts every result and compares.
module grid_point_store_nearest_search_checker import gpsn_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic        func,
	input  logic [31:0] x_key,
	input  logic [31:0] y_key,
	input  logic [63:0] payload,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [1:0]  status,
	input  logic [63:0] found_payload,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data,
	output int          fail_count,
	output int          waiting,
	output int          n_found,
	output int          n_full
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int GRID = 256;
	localparam int POOL = 4096;

	typedef struct packed {
		status_t     st;
		logic [63:0] pay;
	} lookup_result_t;

	lookup_result_t pending_results[$];

	logic [31:0] org_x, org_y, scl_x, scl_y;
	logic [8:0]  cols, rows;
	logic [63:0] tol;

	bit          head_ok[GRID*GRID];
	logic [12:0] head_at[GRID*GRID];
	logic [31:0] pt_x[POOL];
	logic [31:0] pt_y[POOL];
	logic [63:0] pt_pay[POOL];
	bit          next_ok[POOL];
	logic [12:0] next_at[POOL];
	int          stored;

	assign waiting = pending_results.size();

	function automatic longint cell_coord(logic [31:0] key, logic [31:0] org, logic [31:0] scl);
		longint      d;
		logic [63:0] m;
		logic [63:0] p;
		d = longint'($signed(key)) - longint'($signed(org));
		m = d < 0 ? -d : d;
		p = m * {32'b0, scl};
		return d < 0 ? -longint'(p >> 32) : longint'(p >> 32);
	endfunction

	function automatic longint grid_size(logic [8:0] r);
		if (r < 1) return 1;
		if (r > GRID) return GRID;
		return r;
	endfunction

	function automatic longint clamp(longint v, longint n);
		if (v < 0) return 0;
		if (v > n - 1) return n - 1;
		return v;
	endfunction

	function automatic logic [63:0] sq_dist(logic [31:0] ax, logic [31:0] ay,
			logic [31:0] bx, logic [31:0] by);
		longint      dx;
		longint      dy;
		logic [63:0] a;
		logic [63:0] b;
		logic [63:0] s;
		dx = longint'($signed(ax)) - longint'($signed(bx));
		dy = longint'($signed(ay)) - longint'($signed(by));
		if (dx < 0) dx = -dx;
		if (dy < 0) dy = -dy;
		a = dx * dx;
		b = dy * dy;
		s = a + b;
		if (s < a) s = '1;
		return s;
	endfunction

	task automatic lookup_or_store(input logic f, input logic [31:0] xk, input logic [31:0] yk,
			input logic [63:0] pay, output lookup_result_t r);
		longint      nc, nr, cx, cy, gx, gy, x1, x2, y1, y2;
		int          cell_ix, e;
		bit          ok;
		logic [63:0] best, d;
		nc = grid_size(cols);
		nr = grid_size(rows);
		cx = cell_coord(xk, org_x, scl_x);
		cy = cell_coord(yk, org_y, scl_y);
		r.pay = '0;
		if (f == FUNC_INSERT) begin
			if (stored >= POOL) begin
				r.st = ST_FULL;
				n_full++;
				return;
			end
			cell_ix = clamp(cy, nr) * GRID + clamp(cx, nc);
			pt_x[stored] = xk;
			pt_y[stored] = yk;
			pt_pay[stored] = pay;
			next_ok[stored] = head_ok[cell_ix];
			next_at[stored] = head_at[cell_ix];
			head_ok[cell_ix] = 1;
			head_at[cell_ix] = stored;
			stored++;
			r.st = ST_INSERTED;
		end else begin
			x1 = clamp(cx - 1, nc);
			x2 = clamp(cx + 1, nc);
			y1 = clamp(cy - 1, nr);
			y2 = clamp(cy + 1, nr);
			best = tol;
			r.st = ST_NOT_FOUND;
			for (gy = y1; gy <= y2; gy++) begin
				for (gx = x1; gx <= x2; gx++) begin
					cell_ix = gy * GRID + gx;
					ok = head_ok[cell_ix];
					e = head_at[cell_ix];
					while (ok) begin
						d = sq_dist(xk, yk, pt_x[e], pt_y[e]);
						if (best > d) begin
							best = d;
							r.pay = pt_pay[e];
							r.st = ST_FOUND;
						end
						ok = next_ok[e];
						e = next_at[e];
					end
				end
			end
			if (r.st == ST_FOUND) n_found++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		lookup_result_t r;
		lookup_result_t want;
		if (!arst_n) begin
			org_x = '0;
			org_y = '0;
			scl_x = 32'd65536;
			scl_y = 32'd65536;
			cols = 9'd256;
			rows = 9'd256;
			tol = 64'd65536;
			for (int i = 0; i < GRID*GRID; i++) head_ok[i] = 0;
			stored = 0;
			fail_count = 0;
			n_found = 0;
			n_full = 0;
			pending_results.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_ORIGIN_X: org_x = cfg_data[31:0];
					REG_ORIGIN_Y: org_y = cfg_data[31:0];
					REG_SCALE_X:  scl_x = cfg_data[31:0];
					REG_SCALE_Y:  scl_y = cfg_data[31:0];
					REG_COLS:     cols = cfg_data[8:0];
					REG_ROWS:     rows = cfg_data[8:0];
					REG_TOL_SQR:  tol = cfg_data;
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (pending_results.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result transaction: status %0d payload %h",
							status, found_payload);
				end else begin
					want = pending_results.pop_front();
					if (status !== want.st || found_payload !== want.pay) begin
						fail_count++;
						if (fail_count <= 10)
							$display("mismatch: expected status %0d payload %h, got %0d %h",
								want.st, want.pay, status, found_payload);
					end
				end
			end
			if (in_valid && in_ready) begin
				lookup_or_store(func, x_key, y_key, payload, r);
				pending_results.push_back(r);
			end
		end
	end

endmodule

>>> tb/grid_point_store_nearest_search_tb.sv
// Testbench top: drives inserts, finds and register writes into the grid point store.
module grid_point_store_nearest_search_tb;
	import gpsn_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STALL_LIMIT = 200000;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        in_valid = 0;
	logic        in_ready;
	logic        func = FUNC_INSERT;
	logic [31:0] x_key = '0;
	logic [31:0] y_key = '0;
	logic [63:0] payload = '0;
	logic        out_valid;
	logic        out_ready = 0;
	logic [1:0]  status;
	logic [63:0] found_payload;
	logic        cfg_valid = 0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = REG_ORIGIN_X;
	logic [63:0] cfg_data = '0;

	int fail_count, waiting, n_found, n_full;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int stall_cycles = 0;
	int n_items = 0;
	int n_inserts = 0;
	logic [31:0] base_x = '0;
	logic [31:0] base_y = '0;
	logic [31:0] kept_x[$];
	logic [31:0] kept_y[$];

	grid_point_store_nearest_search dut (.*);

	grid_point_store_nearest_search_checker chk (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	always @(negedge clk)
		out_ready <= ($urandom_range(99) >= recv_idle_pct);

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
				(cfg_valid && cfg_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles == STALL_LIMIT) begin
			$display("timeout: no transaction for %0d cycles", STALL_LIMIT);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	task automatic write_reg(input logic [2:0] idx, input logic [63:0] data);
		cfg_index = idx;
		cfg_data = data;
		cfg_valid = 1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 0;
	endtask

	task automatic drain();
		while (waiting != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic send(input logic f, input logic [31:0] xk, input logic [31:0] yk,
			input logic [63:0] pay);
		if ($urandom_range(99) < send_idle_pct)
			repeat ($urandom_range(1, 4)) @(negedge clk);
		func = f;
		x_key = xk;
		y_key = yk;
		payload = pay;
		in_valid = 1;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		in_valid = 0;
		n_items++;
		if (f == FUNC_INSERT) begin
			n_inserts++;
			kept_x.push_back(xk);
			kept_y.push_back(yk);
		end
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	task automatic random_item();
		int          k;
		int          pick;
		logic [31:0] xk, yk;
		pick = $urandom_range(99);
		if (pick < 50 || kept_x.size() == 0) begin
			if ($urandom_range(4) == 0) begin
				xk = $urandom;
				yk = $urandom;
			end else begin
				xk = base_x + $urandom_range(0, 64*65536);
				yk = base_y + $urandom_range(0, 64*65536);
			end
			send(FUNC_INSERT, xk, yk, rand64());
		end else if (pick < 88) begin
			k = $urandom_range(kept_x.size() - 1);
			xk = kept_x[k] + $urandom_range(0, 600) - 300;
			yk = kept_y[k] + $urandom_range(0, 600) - 300;
			if ($urandom_range(3) == 0) begin
				xk = kept_x[k];
				yk = kept_y[k];
			end
			send(FUNC_FIND, xk, yk, rand64());
		end else begin
			send(FUNC_FIND, $urandom, $urandom, rand64());
		end
	endtask

	task automatic random_phase(input int count, input int s_pct, input int r_pct);
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		for (int i = 0; i < count; i++) begin
			random_item();
			if (i == count / 2) drain();
		end
		drain();
	endtask

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: default grid, tight tolerance
		send(FUNC_FIND, 32'd0, 32'd0, '0);
		send(FUNC_INSERT, 32'd0, 32'd0, 64'h0);
		send(FUNC_INSERT, 32'd0, 32'd0, '1);
		send(FUNC_FIND, 32'd0, 32'd0, '0);
		send(FUNC_FIND, 32'd100, 32'hFFFF_FF9C, '0);
		send(FUNC_FIND, 32'd300, 32'd0, '0);
		send(FUNC_INSERT, 32'h8000_0000, 32'h7FFF_FFFF, 64'h8000_0000_0000_0001);
		send(FUNC_INSERT, 32'h7FFF_FFFF, 32'h8000_0000, 64'h7FFF_FFFF_FFFF_FFFE);
		send(FUNC_FIND, 32'h8000_0000, 32'h7FFF_FFFF, '0);
		send(FUNC_FIND, 32'h7FFF_FFFF, 32'h8000_0000, '1);
		send(FUNC_INSERT, 32'h0001_8000, 32'h0002_4000, 64'h1234_5678_9ABC_DEF0);
		send(FUNC_INSERT, 32'h0001_8010, 32'h0002_4000, 64'h0FED_CBA9_8765_4321);
		send(FUNC_FIND, 32'h0001_8008, 32'h0002_4000, '0);
		send(FUNC_FIND, 32'hFFFF_0000, 32'h0100_0000, '0);
		drain();

		// extremes: degenerate grid, zero and full tolerance, extreme origins
		write_reg(REG_COLS, 9'd0);
		write_reg(REG_ROWS, 9'd511);
		write_reg(REG_SCALE_X, 32'd0);
		write_reg(REG_SCALE_Y, 32'hFFFF_FFFF);
		write_reg(REG_ORIGIN_X, 32'h8000_0000);
		write_reg(REG_ORIGIN_Y, 32'h7FFF_FFFF);
		write_reg(REG_TOL_SQR, 64'd0);
		send(FUNC_INSERT, 32'h0000_0005, 32'h7FFF_FFFF, 64'hA5);
		send(FUNC_FIND, 32'h0000_0005, 32'h7FFF_FFFF, '0);
		drain();
		write_reg(REG_TOL_SQR, '1);
		send(FUNC_FIND, 32'h0000_0005, 32'h7FFF_FFFF, '0);
		send(FUNC_FIND, 32'h8000_0000, 32'h8000_0000, '0);
		send(FUNC_INSERT, $urandom, 32'h8000_0000, rand64());
		send(FUNC_FIND, $urandom, $urandom, '0);
		drain();

		write_reg(REG_ORIGIN_X, '0);
		write_reg(REG_ORIGIN_Y, '0);
		write_reg(REG_SCALE_X, 32'd65536);
		write_reg(REG_SCALE_Y, 32'd65536);
		write_reg(REG_COLS, 9'd256);
		write_reg(REG_ROWS, 9'd256);
		write_reg(REG_TOL_SQR, 64'd262144);
		random_phase(450, 24, 84);

		base_x = 32'hFFEC_0000;
		base_y = 32'h0005_0000;
		write_reg(REG_ORIGIN_X, base_x);
		write_reg(REG_ORIGIN_Y, base_y);
		write_reg(REG_SCALE_X, 32'h0002_0000);
		write_reg(REG_SCALE_Y, 32'h0002_0000);
		write_reg(REG_COLS, 9'd100);
		write_reg(REG_ROWS, 9'd200);
		write_reg(REG_TOL_SQR, 64'h100_0000_0000);
		random_phase(450, 84, 24);

		write_reg(REG_SCALE_X, 32'h0000_8000);
		write_reg(REG_SCALE_Y, 32'h0001_8000);
		write_reg(REG_COLS, 9'd256);
		write_reg(REG_ROWS, 9'd1);
		write_reg(REG_TOL_SQR, 64'd65536);
		random_phase(450, 0, 0);

		// closing mix back on the default grid
		write_reg(REG_ORIGIN_X, '0);
		write_reg(REG_ORIGIN_Y, '0);
		write_reg(REG_SCALE_X, 32'd65536);
		write_reg(REG_SCALE_Y, 32'd65536);
		write_reg(REG_ROWS, 9'd256);
		for (int i = 0; i < 20; i++)
			random_item();

		while (waiting != 0) @(negedge clk);
		repeat (50) @(posedge clk);
		$display("covered %0d input transactions (%0d inserts), %0d finds hit, %0d full drops",
			n_items, n_inserts, n_found, n_full);
		$display("grid sizes, origins, scales and tolerances varied across five phases");
		if (fail_count == 0 && waiting == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

>>> sim.f
sv/gpsn_pkg.sv
sv/gpsn_mul.sv
sv/gpsn_store.sv
sv/grid_point_store_nearest_search.sv
tb/grid_point_store_nearest_search_checker.sv
tb/grid_point_store_nearest_search_tb.sv
